// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define BHOC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define BHOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bhoc_pkg.sv =====
// shared types, constants and helpers for the byte histogram overlap check
// no dependencies
package bhoc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int BIN_COUNT  = 256;
  localparam int BIN_BITS   = $clog2(BIN_COUNT);
  localparam int ACC_BITS   = COUNT_BITS + BIN_BITS;
  localparam int THR_BITS   = 17;
  localparam int FIELD_BITS = 16;
  localparam int PROD_BITS  = THR_BITS + COUNT_BITS;
  localparam int CMP_BITS   = ACC_BITS + 16;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_MODEL  = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BIN_BITS-1:0]   bin_t;

  typedef struct packed {
    logic   rd;
    logic   wr;
    bin_t   addr;
    count_t wdata;
  } bank_req_t;

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_INC  = 7'b0000100,
    ST_EVAL = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_CMP  = 7'b0100000,
    ST_SPR  = 7'b1000000
  } state_t;

  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

  function automatic logic [FIELD_BITS-1:0] sat_field(input logic [ACC_BITS-1:0] v);
    return (v > ACC_BITS'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}} : v[FIELD_BITS-1:0];
  endfunction

endpackage

// ===== hdl/bhoc_count_bank.sv =====
// one 256-bin count memory, read-first, registered read data
// depends on bhoc_pkg
module bhoc_count_bank (
  input  logic               clk,
  input  bhoc_pkg::bank_req_t req,
  output bhoc_pkg::count_t   rdata
);

  bhoc_pkg::count_t mem [bhoc_pkg::BIN_COUNT];
  bhoc_pkg::count_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/byte_histogram_overlap_check.sv =====
// top level of the byte histogram overlap check
// depends on bhoc_pkg, bhoc_count_bank and assert_macros.svh

// Sample and model bytes (in_tuser 0 and 1, byte in in_tdata) are counted into
// two 256-bin saturating histograms; each byte item is a read and a write back
// on the bin memory port. An end request (in_tuser 2) walks all 256 bins through
// one shared min-and-accumulate unit, one bin per cycle, then multiplies
// threshold by model length and compares, clearing both histograms on the way.
// One result item follows each end request; in_tready stays low while an item is
// at work. After reset a clearing pass over all 256 bins runs with in_tready low.
// The user must write the threshold on the cfg port only while the block is idle;
// the block itself does not enforce this.
`include "assert_macros.svh"

module byte_histogram_overlap_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // overlap_total, model_length
  output logic [0:0]  out_tuser,  // pass_flag
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  bhoc_pkg::state_t                     state_r, state_nxt;
  logic [bhoc_pkg::BIN_BITS:0]          cnt_r;
  logic                                 is_model_r;
  bhoc_pkg::bin_t                       addr_r;
  logic                                 pipe_vld_r;
  logic [bhoc_pkg::ACC_BITS-1:0]        acc_r;
  logic [bhoc_pkg::PROD_BITS-1:0]       prod_r;
  bhoc_pkg::count_t                     model_cnt_r;
  logic [bhoc_pkg::THR_BITS-1:0]        thr_r;
  logic                                 out_tvalid_r;
  logic [31:0]                          out_tdata_r;
  logic                                 out_pass_r;

  bhoc_pkg::bank_req_t s_req, m_req;
  bhoc_pkg::count_t    s_rd, m_rd;
  bhoc_pkg::count_t    bin_min;
  logic                in_acc;
  logic                out_free;
  logic                walk_issue;

  bhoc_count_bank u_sample (.clk(clk), .req(s_req), .rdata(s_rd));
  bhoc_count_bank u_model  (.clk(clk), .req(m_req), .rdata(m_rd));

  assign in_tready  = (state_r == bhoc_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign walk_issue = (state_r == bhoc_pkg::ST_EVAL) && !cnt_r[bhoc_pkg::BIN_BITS];
  assign bin_min    = (s_rd < m_rd) ? s_rd : m_rd;
  assign cfg_ready  = 1'b1;

  always_comb begin
    s_req = '0;
    m_req = '0;
    s_req.addr = cnt_r[bhoc_pkg::BIN_BITS-1:0];
    m_req.addr = cnt_r[bhoc_pkg::BIN_BITS-1:0];
    unique case (state_r)
      bhoc_pkg::ST_CLR: begin
        s_req.wr = 1'b1;
        m_req.wr = 1'b1;
      end
      bhoc_pkg::ST_IDLE: begin
        s_req.rd   = in_tvalid;
        m_req.rd   = in_tvalid;
        s_req.addr = in_tdata;
        m_req.addr = in_tdata;
      end
      bhoc_pkg::ST_INC: begin
        s_req.addr  = addr_r;
        m_req.addr  = addr_r;
        s_req.wr    = !is_model_r;
        m_req.wr    = is_model_r;
        s_req.wdata = bhoc_pkg::sat_inc(s_rd);
        m_req.wdata = bhoc_pkg::sat_inc(m_rd);
      end
      bhoc_pkg::ST_EVAL: begin
        s_req.rd = walk_issue;
        m_req.rd = walk_issue;
        s_req.wr = walk_issue;
        m_req.wr = walk_issue;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bhoc_pkg::ST_CLR: begin
        if (cnt_r[bhoc_pkg::BIN_BITS-1:0] == bhoc_pkg::BIN_BITS'(bhoc_pkg::BIN_COUNT - 1)) begin
          state_nxt = bhoc_pkg::ST_IDLE;
        end
      end
      bhoc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            bhoc_pkg::REQ_SAMPLE, bhoc_pkg::REQ_MODEL: state_nxt = bhoc_pkg::ST_INC;
            bhoc_pkg::REQ_END:                         state_nxt = bhoc_pkg::ST_EVAL;
            default:                                   state_nxt = bhoc_pkg::ST_IDLE;
          endcase
        end
      end
      bhoc_pkg::ST_INC:  state_nxt = bhoc_pkg::ST_IDLE;
      bhoc_pkg::ST_EVAL: begin
        if (cnt_r[bhoc_pkg::BIN_BITS] && !pipe_vld_r) begin
          state_nxt = bhoc_pkg::ST_MUL;
        end
      end
      bhoc_pkg::ST_MUL:  state_nxt = bhoc_pkg::ST_CMP;
      bhoc_pkg::ST_CMP: begin
        if (out_free) begin
          state_nxt = bhoc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bhoc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bhoc_pkg::ST_CLR;
      cnt_r        <= '0;
      pipe_vld_r   <= 1'b0;
      model_cnt_r  <= '0;
      thr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      // the result load below takes the slot while in the compare state
      if (out_tvalid_r && out_tready && state_r != bhoc_pkg::ST_CMP) begin
        out_tvalid_r <= 1'b0;
      end
      pipe_vld_r <= walk_issue;
      unique case (state_r)
        bhoc_pkg::ST_CLR: begin
          cnt_r <= (state_nxt == bhoc_pkg::ST_IDLE) ? '0 : cnt_r + 1'b1;
        end
        bhoc_pkg::ST_IDLE: begin
          if (in_acc && in_tuser == bhoc_pkg::REQ_END) begin
            cnt_r <= '0;
          end
        end
        bhoc_pkg::ST_INC: begin
          if (is_model_r) begin
            model_cnt_r <= bhoc_pkg::sat_inc(model_cnt_r);
          end
        end
        bhoc_pkg::ST_EVAL: begin
          if (walk_issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        bhoc_pkg::ST_CMP: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            model_cnt_r  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_model_r <= (in_tuser == bhoc_pkg::REQ_MODEL);
      addr_r     <= in_tdata;
      acc_r      <= '0;
    end
    if (pipe_vld_r) begin
      acc_r <= acc_r + bhoc_pkg::ACC_BITS'(bin_min);
    end
    if (state_r == bhoc_pkg::ST_MUL) begin
      prod_r <= bhoc_pkg::PROD_BITS'(thr_r) * bhoc_pkg::PROD_BITS'(model_cnt_r);
    end
    if (state_r == bhoc_pkg::ST_CMP && out_free) begin
      out_pass_r  <= ({acc_r, 16'd0} >= bhoc_pkg::CMP_BITS'(prod_r));
      out_tdata_r <= {bhoc_pkg::sat_field(bhoc_pkg::ACC_BITS'(model_cnt_r)),
                      bhoc_pkg::sat_field(acc_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_pass_r;

  `BHOC_ASSERT_NEXT(a_end_starts_walk, in_acc && in_tuser == bhoc_pkg::REQ_END, state_r == bhoc_pkg::ST_EVAL && cnt_r == '0, "end request did not start the bin walk")
  `BHOC_ASSERT(a_pipe_in_walk, !pipe_vld_r || state_r == bhoc_pkg::ST_EVAL, "walk data outside the walk")
  `BHOC_ASSERT_NEXT(a_result_clears_model, state_r == bhoc_pkg::ST_CMP && out_free, out_tvalid_r && model_cnt_r == '0, "result load did not clear model count")

endmodule

// ===== verif/tb_byte_histogram_overlap_check.sv =====
// self-checking testbench for byte_histogram_overlap_check: streams sample, model and
// end items, predicts each overlap result in a scoreboard class and compares it
// depends on bhoc_pkg and the rtl of byte_histogram_overlap_check
`timescale 1ns / 100ps

module tb_byte_histogram_overlap_check;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 5000;
  localparam int EVAL_SETTLE = 300;

  typedef struct packed {
    logic        pass_flag;
    logic [15:0] overlap_total;
    logic [15:0] model_length;
  } eval_result_t;

  class overlap_scoreboard;
    logic [bhoc_pkg::COUNT_BITS-1:0] sample_hist [bhoc_pkg::BIN_COUNT];
    logic [bhoc_pkg::COUNT_BITS-1:0] model_hist [bhoc_pkg::BIN_COUNT];
    logic [bhoc_pkg::COUNT_BITS-1:0] model_len;
    logic [bhoc_pkg::THR_BITS-1:0]   threshold;
    eval_result_t                    pending_evals [$];
    int                              evals_checked;
    int                              mismatches;

    function new();
      clear_hist();
      threshold     = '0;
      evals_checked = 0;
      mismatches    = 0;
    endfunction

    function void clear_hist();
      foreach (sample_hist[i]) begin
        sample_hist[i] = '0;
        model_hist[i]  = '0;
      end
      model_len = '0;
    endfunction

    function logic [bhoc_pkg::COUNT_BITS-1:0] bump(logic [bhoc_pkg::COUNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function logic [15:0] clip16(logic [31:0] v);
      return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function void note_item(logic [1:0] kind, logic [7:0] data);
      logic [bhoc_pkg::ACC_BITS-1:0] sum;
      logic [47:0]                   lhs;
      logic [47:0]                   rhs;
      eval_result_t                  r;
      int                            i;
      case (kind)
        bhoc_pkg::REQ_SAMPLE: sample_hist[data] = bump(sample_hist[data]);
        bhoc_pkg::REQ_MODEL: begin
          model_hist[data] = bump(model_hist[data]);
          model_len        = bump(model_len);
        end
        bhoc_pkg::REQ_END: begin
          sum = '0;
          for (i = 0; i < bhoc_pkg::BIN_COUNT; i++) begin
            sum += (sample_hist[i] < model_hist[i]) ? sample_hist[i] : model_hist[i];
          end
          lhs             = 48'(sum) << 16;
          rhs             = 48'(threshold) * 48'(model_len);
          r.pass_flag     = (lhs >= rhs);
          r.overlap_total = clip16(32'(sum));
          r.model_length  = clip16(32'(model_len));
          pending_evals.push_back(r);
          clear_hist();
        end
        default: ;
      endcase
    endfunction

    function void check_result(eval_result_t got);
      eval_result_t want;
      if (pending_evals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing pending: pass %0b overlap %0d length %0d",
                   $time, got.pass_flag, got.overlap_total, got.model_length);
        end
        return;
      end
      want = pending_evals.pop_front();
      evals_checked++;
      if (got.pass_flag !== want.pass_flag || got.overlap_total !== want.overlap_total ||
          got.model_length !== want.model_length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: eval %0d expected pass %0b overlap %0d length %0d", $time,
                   evals_checked, want.pass_flag, want.overlap_total, want.model_length);
          $display("%0t: eval %0d got      pass %0b overlap %0d length %0d", $time,
                   evals_checked, got.pass_flag, got.overlap_total, got.model_length);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = bhoc_pkg::REQ_SAMPLE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data   = '0;

  overlap_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int thr_writes    = 0;

  byte_histogram_overlap_check DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check, then pick next ready
  initial begin
    eval_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.pass_flag     = out_tuser[0];
        got.overlap_total = out_tdata[15:0];
        got.model_length  = out_tdata[31:16];
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall = 0;
      else
        stall++;
    end
    $display("no handshake for %0d cycles, %0d evals pending", stall, sb.pending_evals.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(logic [1:0] kind, logic [7:0] data);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, data);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_evals.size() != 0) @(posedge clk);
    repeat (EVAL_SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(logic [16:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    sb.threshold  = value;
    thr_writes++;
  endtask

  // one load of sample and model bytes around a random alphabet, usually closed by an end
  task automatic run_sequence(int max_len);
    int         n_samp;
    int         n_model;
    int         span;
    logic [7:0] base;
    n_samp  = $urandom_range(0, max_len);
    n_model = $urandom_range(0, max_len);
    base    = 8'($urandom);
    span    = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 12);
    while (n_samp + n_model > 0) begin
      if ($urandom_range(19) == 0) send_item(REQ_UNUSED, 8'($urandom));
      if (n_model == 0 || (n_samp > 0 && $urandom_range(1) == 1)) begin
        send_item(bhoc_pkg::REQ_SAMPLE, 8'(base + $urandom_range(0, span)));
        n_samp--;
      end else begin
        send_item(bhoc_pkg::REQ_MODEL, 8'(base + $urandom_range(0, span)));
        n_model--;
      end
    end
    if ($urandom_range(24) != 0) send_item(bhoc_pkg::REQ_END, 8'($urandom));
  endtask

  task automatic run_random(int target, int send_pct, int recv_pct, int hold);
    int start;
    int seqs;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_left     = hold;
    start         = items_sent;
    seqs          = 0;
    while (items_sent - start < target || seqs < 15) begin
      run_sequence(30);
      seqs++;
    end
    send_item(bhoc_pkg::REQ_END, 8'($urandom));
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset threshold of zero, empty model, unused request code
    send_item(bhoc_pkg::REQ_END, 8'h00);
    send_item(REQ_UNUSED, 8'hFF);
    send_item(bhoc_pkg::REQ_SAMPLE, 8'h00);
    send_item(bhoc_pkg::REQ_SAMPLE, 8'hFF);
    send_item(bhoc_pkg::REQ_SAMPLE, 8'h55);
    send_item(bhoc_pkg::REQ_MODEL, 8'h00);
    send_item(bhoc_pkg::REQ_MODEL, 8'hFF);
    send_item(bhoc_pkg::REQ_MODEL, 8'hAA);
    send_item(bhoc_pkg::REQ_MODEL, 8'hAA);
    send_item(bhoc_pkg::REQ_END, 8'hFF);

    // threshold above one
    write_threshold(17'h1FFFF);
    send_item(bhoc_pkg::REQ_END, 8'h3C);
    send_item(bhoc_pkg::REQ_SAMPLE, 8'h7E);
    send_item(bhoc_pkg::REQ_SAMPLE, 8'h7E);
    send_item(bhoc_pkg::REQ_MODEL, 8'h7E);
    send_item(bhoc_pkg::REQ_END, 8'hC3);

    // exactly one: equality passes, half fails
    write_threshold(17'h10000);
    send_item(bhoc_pkg::REQ_SAMPLE, 8'h81);
    send_item(bhoc_pkg::REQ_MODEL, 8'h81);
    send_item(REQ_UNUSED, 8'h81);
    send_item(bhoc_pkg::REQ_END, 8'h00);
    send_item(bhoc_pkg::REQ_SAMPLE, 8'h01);
    send_item(bhoc_pkg::REQ_MODEL, 8'h01);
    send_item(bhoc_pkg::REQ_MODEL, 8'h02);
    send_item(bhoc_pkg::REQ_END, 8'h00);

    write_threshold(17'($urandom_range(0, 65536)));
    run_random(450, 18, 85, 0);
    write_threshold(17'($urandom_range(0, 65536)));
    run_random(450, 85, 18, 0);
    write_threshold(17'($urandom_range(0, 17'h1FFFF)));
    run_random(400, 0, 0, 800);

    $display("sent %0d counted items, checked %0d evaluations over %0d threshold writes",
             items_sent, sb.evals_checked, thr_writes);
    $display("run included empty models, over-unity thresholds, long output stall");
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
